>>> design/sgi_pkg.sv
// shared constants for the segment intersection block
// no dependencies
`default_nettype none

package sgi_pkg;

    localparam int PAD_BITS = 10;
    localparam logic [PAD_BITS-1:0] PAD_RESET = 10'd10;

    // depth of the queue between front and back, and of the result queue
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

endpackage

`default_nettype wire

>>> design/sgi_fifo.sv
// small register queue with push/full and pop/empty sides
// depends on nothing
`default_nettype none

module sgi_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

>>> design/sgi_front.sv
// front pipeline: line forms, determinant, numerators and box bounds
// depends on sgi_pkg
`default_nettype none

module sgi_front #(
    parameter int CB = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [CB-1:0]          a_start_z,
    input  logic signed [CB-1:0]          a_start_y,
    input  logic signed [CB-1:0]          a_end_z,
    input  logic signed [CB-1:0]          a_end_y,
    input  logic signed [CB-1:0]          b_start_z,
    input  logic signed [CB-1:0]          b_start_y,
    input  logic signed [CB-1:0]          b_end_z,
    input  logic signed [CB-1:0]          b_end_y,
    input  logic [sgi_pkg::PAD_BITS-1:0]  pad,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*(3*CB+4)+(2*CB+3)+1+4*(CB+1)-1:0] out_data
);

    import sgi_pkg::*;

    localparam int D   = CB + 1;
    localparam int PW  = D + CB;
    localparam int DP  = 2 * D;
    localparam int CW  = 2 * CB + 2;
    localparam int DW  = 2 * D + 1;
    localparam int LO  = CB + 1;
    localparam int HI  = CW - LO;
    localparam int PPW = D + LO + 1;
    localparam int HPW = D + HI;
    localparam int LZW = PPW + 1;
    localparam int HZW = HPW + 1;
    localparam int NW  = 3 * CB + 4;
    localparam int BW  = CB + 1;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1: differences and padded box bounds
    logic signed [D-1:0]  ya1_reg, xa1_reg, yb1_reg, xb1_reg;
    logic signed [CB-1:0] asz1_reg, asy1_reg, bsz1_reg, bsy1_reg;
    logic [4*BW-1:0]      bnd1_reg, bnd1_next;

    logic signed [CB-1:0] amin_z, amax_z, bmin_z, bmax_z;
    logic signed [CB-1:0] amin_y, amax_y, bmin_y, bmax_y;
    logic signed [CB-1:0] lo_z, hi_z, lo_y, hi_y;
    logic signed [BW-1:0] pad_s;

    always_comb
    begin
        amin_z = (a_start_z < a_end_z) ? a_start_z : a_end_z;
        amax_z = (a_start_z > a_end_z) ? a_start_z : a_end_z;
        bmin_z = (b_start_z < b_end_z) ? b_start_z : b_end_z;
        bmax_z = (b_start_z > b_end_z) ? b_start_z : b_end_z;
        amin_y = (a_start_y < a_end_y) ? a_start_y : a_end_y;
        amax_y = (a_start_y > a_end_y) ? a_start_y : a_end_y;
        bmin_y = (b_start_y < b_end_y) ? b_start_y : b_end_y;
        bmax_y = (b_start_y > b_end_y) ? b_start_y : b_end_y;
        // overlap of the two boxes
        lo_z   = (amin_z > bmin_z) ? amin_z : bmin_z;
        hi_z   = (amax_z < bmax_z) ? amax_z : bmax_z;
        lo_y   = (amin_y > bmin_y) ? amin_y : bmin_y;
        hi_y   = (amax_y < bmax_y) ? amax_y : bmax_y;
        pad_s  = BW'($signed({1'b0, pad}));
        bnd1_next = {BW'(lo_z) - pad_s, BW'(hi_z) + pad_s,
                     BW'(lo_y) - pad_s, BW'(hi_y) + pad_s};
    end

    // stage 2: products for line constants and determinant
    logic signed [D-1:0]  ya2_reg, xa2_reg, yb2_reg, xb2_reg;
    logic signed [PW-1:0] p_ya_asz2_reg, p_xa_asy2_reg, p_yb_bsz2_reg, p_xb_bsy2_reg;
    logic signed [DP-1:0] p_ya_xb2_reg, p_yb_xa2_reg;
    logic [4*BW-1:0]      bnd2_reg;

    // stage 3: line constants and determinant
    logic signed [D-1:0]  ya3_reg, xa3_reg, yb3_reg, xb3_reg;
    logic signed [CW-1:0] ca3_reg, cb3_reg;
    logic signed [DW-1:0] det3_reg;
    logic [4*BW-1:0]      bnd3_reg;

    // stage 4: split partial products of the numerators
    logic signed [PPW-1:0] m_xb_cal4_reg, m_xa_cbl4_reg, m_ya_cbl4_reg, m_yb_cal4_reg;
    logic signed [HPW-1:0] m_xb_cah4_reg, m_xa_cbh4_reg, m_ya_cbh4_reg, m_yb_cah4_reg;
    logic signed [DW-1:0]  det4_reg;
    logic                  par4_reg;
    logic [4*BW-1:0]       bnd4_reg;

    logic signed [PPW-1:0] cal_s, cbl_s;
    logic signed [HPW-1:0] cah_s, cbh_s;

    assign cal_s = PPW'($signed({1'b0, ca3_reg[LO-1:0]}));
    assign cbl_s = PPW'($signed({1'b0, cb3_reg[LO-1:0]}));
    assign cah_s = HPW'($signed(ca3_reg[CW-1:LO]));
    assign cbh_s = HPW'($signed(cb3_reg[CW-1:LO]));

    // stage 5: partial differences
    logic signed [LZW-1:0] lz5_reg, ly5_reg;
    logic signed [HZW-1:0] hz5_reg, hy5_reg;
    logic signed [DW-1:0]  det5_reg;
    logic                  par5_reg;
    logic [4*BW-1:0]       bnd5_reg;

    // stage 6: full numerators
    logic signed [NW-1:0]  nz6_reg, ny6_reg;
    logic signed [DW-1:0]  det6_reg;
    logic                  par6_reg;
    logic [4*BW-1:0]       bnd6_reg;

    assign en        = !v6_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v6_reg;
    assign out_data  = {nz6_reg, ny6_reg, det6_reg, par6_reg, bnd6_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ya1_reg  <= D'(a_end_y) - D'(a_start_y);
            xa1_reg  <= D'(a_start_z) - D'(a_end_z);
            yb1_reg  <= D'(b_end_y) - D'(b_start_y);
            xb1_reg  <= D'(b_start_z) - D'(b_end_z);
            asz1_reg <= a_start_z;
            asy1_reg <= a_start_y;
            bsz1_reg <= b_start_z;
            bsy1_reg <= b_start_y;
            bnd1_reg <= bnd1_next;

            ya2_reg       <= ya1_reg;
            xa2_reg       <= xa1_reg;
            yb2_reg       <= yb1_reg;
            xb2_reg       <= xb1_reg;
            p_ya_asz2_reg <= PW'(ya1_reg) * PW'(asz1_reg);
            p_xa_asy2_reg <= PW'(xa1_reg) * PW'(asy1_reg);
            p_yb_bsz2_reg <= PW'(yb1_reg) * PW'(bsz1_reg);
            p_xb_bsy2_reg <= PW'(xb1_reg) * PW'(bsy1_reg);
            p_ya_xb2_reg  <= DP'(ya1_reg) * DP'(xb1_reg);
            p_yb_xa2_reg  <= DP'(yb1_reg) * DP'(xa1_reg);
            bnd2_reg      <= bnd1_reg;

            ya3_reg  <= ya2_reg;
            xa3_reg  <= xa2_reg;
            yb3_reg  <= yb2_reg;
            xb3_reg  <= xb2_reg;
            ca3_reg  <= CW'(p_ya_asz2_reg) + CW'(p_xa_asy2_reg);
            cb3_reg  <= CW'(p_yb_bsz2_reg) + CW'(p_xb_bsy2_reg);
            det3_reg <= DW'(p_ya_xb2_reg) - DW'(p_yb_xa2_reg);
            bnd3_reg <= bnd2_reg;

            m_xb_cal4_reg <= PPW'(xb3_reg) * cal_s;
            m_xa_cbl4_reg <= PPW'(xa3_reg) * cbl_s;
            m_ya_cbl4_reg <= PPW'(ya3_reg) * cbl_s;
            m_yb_cal4_reg <= PPW'(yb3_reg) * cal_s;
            m_xb_cah4_reg <= HPW'(xb3_reg) * cah_s;
            m_xa_cbh4_reg <= HPW'(xa3_reg) * cbh_s;
            m_ya_cbh4_reg <= HPW'(ya3_reg) * cbh_s;
            m_yb_cah4_reg <= HPW'(yb3_reg) * cah_s;
            det4_reg      <= det3_reg;
            par4_reg      <= (det3_reg == '0);
            bnd4_reg      <= bnd3_reg;

            lz5_reg  <= LZW'(m_xb_cal4_reg) - LZW'(m_xa_cbl4_reg);
            hz5_reg  <= HZW'(m_xb_cah4_reg) - HZW'(m_xa_cbh4_reg);
            ly5_reg  <= LZW'(m_ya_cbl4_reg) - LZW'(m_yb_cal4_reg);
            hy5_reg  <= HZW'(m_ya_cbh4_reg) - HZW'(m_yb_cah4_reg);
            det5_reg <= det4_reg;
            par5_reg <= par4_reg;
            bnd5_reg <= bnd4_reg;

            nz6_reg  <= (NW'(hz5_reg) <<< LO) + NW'(lz5_reg);
            ny6_reg  <= (NW'(hy5_reg) <<< LO) + NW'(ly5_reg);
            det6_reg <= det5_reg;
            par6_reg <= par5_reg;
            bnd6_reg <= bnd5_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/sgi_back.sv
// back pipeline: rounded restoring division, clamping and box test
// depends on sgi_pkg
`default_nettype none

module sgi_back #(
    parameter int CB = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2*(3*CB+4)+(2*CB+3)+1+4*(CB+1)-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2*CB+2:0]      out_data
);

    import sgi_pkg::*;

    localparam int NW  = 3 * CB + 4;
    localparam int DW  = 2 * CB + 3;
    localparam int BW  = CB + 1;
    localparam int RW  = NW + 2;
    localparam int QW  = CB + 1;
    localparam int NS  = CB + 1;
    localparam int BBW = 4 * BW;

    localparam logic signed [BW-1:0] CMAX = {2'b00, {(CB-1){1'b1}}};
    localparam logic signed [BW-1:0] CMIN = {2'b11, {(CB-1){1'b0}}};

    logic signed [NW-1:0] nz_in, ny_in;
    logic signed [DW-1:0] det_in;
    logic                 par_in;
    logic [BBW-1:0]       bnd_in;

    assign {nz_in, ny_in, det_in, par_in, bnd_in} = in_data;

    logic en;

    // stage 0: magnitudes and quotient signs
    logic            v0_reg;
    logic [NW-1:0]   anz0_reg, any0_reg;
    logic [DW-1:0]   ad0_reg;
    logic            sz0_reg, sy0_reg, par0_reg;
    logic [BBW-1:0]  bnd0_reg;

    // division stages, index 0 holds the scaled dividend and divisor
    logic           dv_reg  [NS+1];
    logic [RW-1:0]  rz_reg  [NS];
    logic [RW-1:0]  ry_reg  [NS];
    logic [QW-1:0]  qz_reg  [NS+1];
    logic [QW-1:0]  qy_reg  [NS+1];
    logic [DW:0]    dd_reg  [NS];
    logic           sz_reg  [NS+1];
    logic           sy_reg  [NS+1];
    logic           par_reg [NS+1];
    logic [BBW-1:0] bnd_reg [NS+1];

    // result stage
    logic            vf_reg;
    logic [2*CB+2:0] res_reg, res_next;

    assign en        = !vf_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = vf_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            vf_reg    <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            dv_reg[0] <= v0_reg;
            vf_reg    <= dv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            anz0_reg <= nz_in[NW-1] ? (~nz_in + 1'b1) : nz_in;
            any0_reg <= ny_in[NW-1] ? (~ny_in + 1'b1) : ny_in;
            ad0_reg  <= det_in[DW-1] ? (~det_in + 1'b1) : det_in;
            sz0_reg  <= nz_in[NW-1] ^ det_in[DW-1];
            sy0_reg  <= ny_in[NW-1] ^ det_in[DW-1];
            par0_reg <= par_in;
            bnd0_reg <= bnd_in;

            // round half away: (2|n| + |d|) / (2|d|)
            rz_reg[0]  <= RW'({anz0_reg, 1'b0}) + RW'(ad0_reg);
            ry_reg[0]  <= RW'({any0_reg, 1'b0}) + RW'(ad0_reg);
            qz_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            dd_reg[0]  <= {ad0_reg, 1'b0};
            sz_reg[0]  <= sz0_reg;
            sy_reg[0]  <= sy0_reg;
            par_reg[0] <= par0_reg;
            bnd_reg[0] <= bnd0_reg;

            res_reg <= res_next;
        end
    end

    // one quotient bit per stage; the top bit flags a quotient out of range
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [RW-1:0] sh;
        logic          ge_z, ge_y;

        assign sh   = RW'(dd_reg[k]) << (CB - k);
        assign ge_z = (rz_reg[k] >= sh);
        assign ge_y = (ry_reg[k] >= sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qz_reg[k+1]  <= {qz_reg[k][QW-2:0], ge_z};
                qy_reg[k+1]  <= {qy_reg[k][QW-2:0], ge_y};
                sz_reg[k+1]  <= sz_reg[k];
                sy_reg[k+1]  <= sy_reg[k];
                par_reg[k+1] <= par_reg[k];
                bnd_reg[k+1] <= bnd_reg[k];
            end
        end

        // the last stage needs no remainder
        if (k < NS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rz_reg[k+1] <= ge_z ? (rz_reg[k] - sh) : rz_reg[k];
                    ry_reg[k+1] <= ge_y ? (ry_reg[k] - sh) : ry_reg[k];
                    dd_reg[k+1] <= dd_reg[k];
                end
            end
        end
    end

    logic                 ovf_z, ovf_y;
    logic signed [BW-1:0] mag_z, mag_y, val_z, val_y, cl_z, cl_y;
    logic signed [BW-1:0] zlo, zhi, ylo, yhi;
    logic                 sat_z, sat_y, in_box;

    always_comb
    begin
        ovf_z = qz_reg[NS][CB];
        ovf_y = qy_reg[NS][CB];
        mag_z = BW'($signed({1'b0, qz_reg[NS][CB-1:0]}));
        mag_y = BW'($signed({1'b0, qy_reg[NS][CB-1:0]}));
        val_z = sz_reg[NS] ? -mag_z : mag_z;
        val_y = sy_reg[NS] ? -mag_y : mag_y;
        {zlo, zhi, ylo, yhi} = bnd_reg[NS];

        sat_z = ovf_z || (val_z > CMAX) || (val_z < CMIN);
        sat_y = ovf_y || (val_y > CMAX) || (val_y < CMIN);

        if (ovf_z)
            cl_z = sz_reg[NS] ? CMIN : CMAX;
        else if (val_z > CMAX)
            cl_z = CMAX;
        else if (val_z < CMIN)
            cl_z = CMIN;
        else
            cl_z = val_z;

        if (ovf_y)
            cl_y = sy_reg[NS] ? CMIN : CMAX;
        else if (val_y > CMAX)
            cl_y = CMAX;
        else if (val_y < CMIN)
            cl_y = CMIN;
        else
            cl_y = val_y;

        in_box = !ovf_z && !ovf_y && (val_z >= zlo) && (val_z <= zhi)
                 && (val_y >= ylo) && (val_y <= yhi);

        if (par_reg[NS])
            res_next = {{(2*CB){1'b0}}, 1'b0, 1'b1, 1'b0};
        else
            res_next = {cl_z[CB-1:0], cl_y[CB-1:0], in_box, 1'b0, sat_z || sat_y};
    end

endmodule

`default_nettype wire

>>> design/segment_intersection_2d.sv
// top level of the 2d segment intersection block
// depends on sgi_pkg, sgi_front, sgi_fifo, sgi_back
//
//  channel   ports                                    direction  beat when
//  input     push, full, a_*/b_* coordinates          in         push && !full
//  result    pop, empty, hit_z, hit_y, flags          out        pop && !empty
//  config    cfg_write, cfg_data (box_padding)        in         cfg_write
//
// one beat per cycle sustained unless a queue fills; a beat passes 6 front
// stages, the middle queue, COORD_BITS+4 back stages (one quotient bit per
// division stage) and the result queue. reset clears all valid flags and
// sets box_padding to 10. front and back stall separately: the front holds
// when the middle queue is full, the back holds when the result queue is full.
`default_nettype none

module segment_intersection_2d #(
    parameter int COORD_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  a_start_z,
    input  logic signed [COORD_BITS-1:0]  a_start_y,
    input  logic signed [COORD_BITS-1:0]  a_end_z,
    input  logic signed [COORD_BITS-1:0]  a_end_y,
    input  logic signed [COORD_BITS-1:0]  b_start_z,
    input  logic signed [COORD_BITS-1:0]  b_start_y,
    input  logic signed [COORD_BITS-1:0]  b_end_z,
    input  logic signed [COORD_BITS-1:0]  b_end_y,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [COORD_BITS-1:0]  hit_z,
    output logic signed [COORD_BITS-1:0]  hit_y,
    output logic                          crosses,
    output logic                          parallel,
    output logic                          saturated,
    input  logic                          cfg_write,
    input  logic [sgi_pkg::PAD_BITS-1:0]  cfg_data
);

    import sgi_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MW = 2 * (3 * CB + 4) + (2 * CB + 3) + 1 + 4 * (CB + 1);
    localparam int RW = 2 * CB + 3;

    logic [PAD_BITS-1:0] pad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= PAD_RESET;
        else if (cfg_write)
            pad_reg <= cfg_data;
    end

    logic          front_ready, front_valid, mid_full, mid_empty;
    logic [MW-1:0] front_data, mid_data;
    logic          back_ready, back_valid, out_full;
    logic [RW-1:0] back_data, out_data;

    assign full = !front_ready;

    sgi_front #(
        .CB (CB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (front_ready),
        .a_start_z (a_start_z),
        .a_start_y (a_start_y),
        .a_end_z   (a_end_z),
        .a_end_y   (a_end_y),
        .b_start_z (b_start_z),
        .b_start_y (b_start_y),
        .b_end_z   (b_end_z),
        .b_end_y   (b_end_y),
        .pad       (pad_reg),
        .out_valid (front_valid),
        .out_ready (!mid_full),
        .out_data  (front_data)
    );

    sgi_fifo #(
        .W     (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .full  (mid_full),
        .din   (front_data),
        .pop   (back_ready),
        .empty (mid_empty),
        .dout  (mid_data)
    );

    sgi_back #(
        .CB (CB)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_ready  (back_ready),
        .in_data   (mid_data),
        .out_valid (back_valid),
        .out_ready (!out_full),
        .out_data  (back_data)
    );

    sgi_fifo #(
        .W     (RW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .full  (out_full),
        .din   (back_data),
        .pop   (pop),
        .empty (empty),
        .dout  (out_data)
    );

    assign hit_z     = out_data[RW-1:CB+3];
    assign hit_y     = out_data[CB+2:3];
    assign crosses   = out_data[2];
    assign parallel  = out_data[1];
    assign saturated = out_data[0];

endmodule

`default_nettype wire

>>> dv/segment_intersection_2d_tb.sv
// self-checking testbench for segment_intersection_2d: random and directed segment pairs
// with exact intersection prediction in 128-bit arithmetic; depends on sgi_pkg and the dut
`timescale 1ns / 100ps
`default_nettype none

module segment_intersection_2d_tb;
    import sgi_pkg::*;

    localparam int CB = 20;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [CB-1:0] CMAX = 20'sh7ffff;
    localparam logic signed [CB-1:0] CMIN = 20'sh80000;

    typedef struct packed {
        logic signed [CB-1:0] asz, asy, aez, aey, bsz, bsy, bez, bey;
    } seg_pair_t;

    typedef struct packed {
        logic signed [CB-1:0] hz, hy;
        logic cr, par, sat;
    } hit_t;

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic cfg_write = 0;
    logic [PAD_BITS-1:0] cfg_data = '0;
    logic full, empty, crosses, parallel, saturated;
    logic signed [CB-1:0] hit_z, hit_y;
    seg_pair_t drv = '0;

    seg_pair_t pending_pairs[$];
    hit_t expected_hits[$];
    logic [PAD_BITS-1:0] padding = PAD_RESET;
    int mismatches = 0;
    bit send_idle_ok = 1;
    bit recv_idle_ok = 1;
    bit hold_go = 0;
    bit recv_holding = 0;
    longint cycles = 0;

    segment_intersection_2d dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_start_z(drv.asz), .a_start_y(drv.asy), .a_end_z(drv.aez), .a_end_y(drv.aey),
        .b_start_z(drv.bsz), .b_start_y(drv.bsy), .b_end_z(drv.bez), .b_end_y(drv.bey),
        .pop(pop), .empty(empty), .hit_z(hit_z), .hit_y(hit_y), .crosses(crosses),
        .parallel(parallel), .saturated(saturated), .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // rounded quotient, ties away from zero; big when magnitude exceeds 2^62
    function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
            input logic signed [127:0] d, output bit big);
        logic [127:0] an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        big = q > (128'd1 << 62);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic bit in_box(input logic signed [127:0] v, input logic signed [CB-1:0] s,
            input logic signed [CB-1:0] e);
        logic signed [127:0] lo, hi;
        lo = (s < e ? s : e) - $signed({1'b0, padding});
        hi = (s > e ? s : e) + $signed({1'b0, padding});
        return v >= lo && v <= hi;
    endfunction

    function automatic logic signed [CB-1:0] clamp_coord(input logic signed [127:0] v,
            input bit big, inout bit sat);
        if (big || v > CMAX || v < CMIN)
        begin
            sat = 1;
            return (v < 0) ? CMIN : CMAX;
        end
        return v[CB-1:0];
    endfunction

    function automatic hit_t predict_hit(input seg_pair_t p);
        logic signed [127:0] ya, xa, yb, xb, ca, cb, det, z, y;
        bit bz, by, sat;
        hit_t h;
        h = '0;
        sat = 0;
        ya = p.aey - p.asy; xa = p.asz - p.aez;
        yb = p.bey - p.bsy; xb = p.bsz - p.bez;
        ca = ya * p.asz + xa * p.asy;
        cb = yb * p.bsz + xb * p.bsy;
        det = ya * xb - yb * xa;
        if (det == 0)
        begin
            h.par = 1;
            return h;
        end
        z = round_div(xb * ca - xa * cb, det, bz);
        y = round_div(ya * cb - yb * ca, det, by);
        h.cr = !bz && !by && in_box(z, p.asz, p.aez) && in_box(z, p.bsz, p.bez)
            && in_box(y, p.asy, p.aey) && in_box(y, p.bsy, p.bey);
        h.hz = clamp_coord(z, bz, sat);
        h.hy = clamp_coord(y, by, sat);
        h.sat = sat;
        return h;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return CMAX;
        if (r == 1) return CMIN;
        if (r < 4) return CB'($urandom);
        return CB'($signed(CB'($urandom_range(0, 2 * span))) - span);
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int span;
        span = ($urandom_range(0, 3) == 0) ? 524287 : $urandom_range(1, 4000);
        p.asz = rand_coord(span); p.asy = rand_coord(span);
        p.aez = rand_coord(span); p.aey = rand_coord(span);
        p.bsz = rand_coord(span); p.bsy = rand_coord(span);
        p.bez = rand_coord(span); p.bey = rand_coord(span);
        case ($urandom_range(0, 7))
            0: begin p.bez = p.bsz + (p.aez - p.asz); p.bey = p.bsy + (p.aey - p.asy); end
            1: begin p.bez = p.bsz; p.bey = p.bsy; end
            2: begin p.aez = p.asz + 1; p.bez = p.bsz; end
            default: ;
        endcase
        return p;
    endfunction

    // driver: offer the head of the pending queue, idle now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_hits.insert(expected_hits.size(), predict_hit(drv));
                void'(pending_pairs.pop_front());
            end
            if (pending_pairs.size() > 0 && !(send_idle_ok && $urandom_range(0, 99) < 20))
            begin
                push <= 1;
                drv <= pending_pairs[0];
            end
            else
                push <= 0;
        end
    end

    // long receiver hold, counted in cycles
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        recv_holding <= 1;
        repeat (300) @(posedge clk);
        recv_holding <= 0;
    end

    // monitor: check every result beat against the oldest prediction
    always @(posedge clk)
    begin
        hit_t got, want;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = '{hit_z, hit_y, crosses, parallel, saturated};
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (recv_holding)
                pop <= 0;
            else
                pop <= !(recv_idle_ok && $urandom_range(0, 99) < 20);
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
            pending_pairs.insert(pending_pairs.size(), rand_pair());
        wait (pending_pairs.size() == 0 && !push);
        wait (expected_hits.size() == 0);
    endtask

    task automatic set_padding(input logic [PAD_BITS-1:0] v);
        repeat (40) @(posedge clk);
        cfg_data <= v;
        cfg_write <= 1;
        @(posedge clk);
        cfg_write <= 0;
        padding = v;
    endtask

    task automatic add_pair(input int asz, asy, aez, aey, bsz, bsy, bez, bey);
        pending_pairs.insert(pending_pairs.size(), '{CB'(asz), CB'(asy), CB'(aez), CB'(aey),
            CB'(bsz), CB'(bsy), CB'(bez), CB'(bey)});
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // directed: plain cross, touching ends, parallel, degenerate, far and extreme points
        add_pair(-640, 0, 640, 0, 0, -640, 0, 640);
        add_pair(0, 0, 640, 640, 640, 0, 1280, -640);
        add_pair(0, 0, 640, 0, 0, 64, 640, 64);
        add_pair(5, 5, 5, 5, 0, 0, 100, 100);
        add_pair(0, 0, 1, 0, 0, 0, 0, 0);
        add_pair(0, 0, 64, 1, 0, 1, 64, 0);
        add_pair(0, 0, 1, 1, 0, 10, 1, 10);
        add_pair(0, 0, 1, 2, 1, 0, 2, 1);
        add_pair(0, 0, 10, 0, 21, -5, 21, 5);
        add_pair(0, 0, 10, 0, 20, -5, 20, 5);
        add_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        add_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
        add_pair(0, 0, 1, 1, 0, 1, 3, 3);
        add_pair(0, 0, 1, 1, 0, -1, 3, 3);
        add_pair(524287, 0, 524286, 1, 0, 0, 1, 1);
        add_pair(-1, -1, 1, 1, 1, -1, -1, 1);
        add_pair(0, 0, 2, 1, 0, 1, 2, 0);
        add_pair(0, 0, 2, -1, 0, -1, 2, 0);
        run_phase(0);
        set_padding(0);
        add_pair(0, 0, 10, 0, 11, -5, 11, 5);
        add_pair(0, 0, 10, 0, 10, -5, 10, 5);
        run_phase(150);
        set_padding(1023);
        add_pair(0, 0, 10, 0, 1033, -5, 1033, 5);
        add_pair(0, 0, 10, 0, 1034, -5, 1034, 5);
        run_phase(200);
        // long back-pressure so the pipeline fills and full rises
        hold_go = 1;
        run_phase(200);
        set_padding(PAD_BITS'($urandom_range(1, 1022)));
        send_idle_ok = 0;
        recv_idle_ok = 0;
        run_phase(300);
        send_idle_ok = 1;
        recv_idle_ok = 1;
        set_padding(PAD_RESET);
        run_phase(700);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
design/sgi_pkg.sv
design/sgi_fifo.sv
design/sgi_front.sv
design/sgi_back.sv
design/segment_intersection_2d.sv
dv/segment_intersection_2d_tb.sv
